/* sv/aes_round_instruction_unit_macros.svh */
// Assertion macros for the AES round instruction unit.
// Used by the top level; no other dependencies.
`ifndef AES_ROUND_INSTRUCTION_UNIT_MACROS_SVH
`define AES_ROUND_INSTRUCTION_UNIT_MACROS_SVH

// Assert a property on the rising clock edge, disabled in reset.
`define ARIU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert a property that also holds during reset.
`define ARIU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/ariu_pkg.sv */
// Package for the AES round instruction unit: types, action codes and
// GF(2^8) / S-box functions. No dependencies.
package ariu_pkg;

  localparam int unsigned HALF_W = 64;
  localparam logic [7:0] AES_POLY_LOW = 8'h1B;

  typedef enum logic [2:0] {
    ACT_ENC      = 3'd0,
    ACT_ENC_LAST = 3'd1,
    ACT_DEC      = 3'd2,
    ACT_DEC_LAST = 3'd3,
    ACT_IMC      = 3'd4
  } action_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] block_t;

  function automatic byte_t xtime(input byte_t x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? AES_POLY_LOW : 8'h00);
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t t;
    acc = '0;
    t = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ t;
      t = xtime(t);
    end
    gf_mul = acc;
  endfunction

  // Inverse in GF(2^8) by a fixed addition chain for x^254.
  function automatic byte_t gf_inv(input byte_t x);
    byte_t x2, x3, x6, x7, x14, x15, x30, x60, x120, x127, x254;
    x2 = gf_mul(x, x);
    x3 = gf_mul(x2, x);
    x6 = gf_mul(x3, x3);
    x7 = gf_mul(x6, x);
    x14 = gf_mul(x7, x7);
    x15 = gf_mul(x14, x);
    x30 = gf_mul(x15, x15);
    x60 = gf_mul(x30, x30);
    x120 = gf_mul(x60, x60);
    x127 = gf_mul(x120, x7);
    x254 = gf_mul(x127, x127);
    gf_inv = x254;
  endfunction

  function automatic byte_t rotl8(input byte_t v, input int unsigned n);
    byte_t w;
    w = v;
    for (int i = 0; i < 8; i++) begin
      if (i < n) w = {w[6:0], w[7]};
    end
    rotl8 = w;
  endfunction

  function automatic byte_t sbox_f(input byte_t x);
    byte_t b;
    b = gf_inv(x);
    sbox_f = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t inv_sub_f(input byte_t x);
    inv_sub_f = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
  endfunction

  // Constant S-box tables, evaluated at elaboration.
  function automatic block_t [15:0] make_sbox(input logic inverse);
    block_t [15:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i / 16][i % 16] = inverse ? inv_sub_f(byte_t'(i)) : sbox_f(byte_t'(i));
    end
    make_sbox = t;
  endfunction

  localparam block_t [15:0] SBOX        = make_sbox(1'b0);
  localparam block_t [15:0] INV_SUB_TBL = make_sbox(1'b1);

endpackage

/* sv/ariu_if.sv */
// Valid/ready channel interface for the AES round instruction unit.
// Depends on ariu_pkg for payload widths.
interface ariu_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [2:0] action;
  logic [ariu_pkg::HALF_W-1:0] state_lo;
  logic [ariu_pkg::HALF_W-1:0] state_hi;
  logic [ariu_pkg::HALF_W-1:0] round_key_lo;
  logic [ariu_pkg::HALF_W-1:0] round_key_hi;
  modport source (output valid, action, state_lo, state_hi, round_key_lo, round_key_hi,
                  input ready);
  modport sink (input valid, action, state_lo, state_hi, round_key_lo, round_key_hi,
                output ready);
endinterface

interface ariu_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [ariu_pkg::HALF_W-1:0] result_lo;
  logic [ariu_pkg::HALF_W-1:0] result_hi;
  modport source (output valid, result_lo, result_hi, input ready);
  modport sink (input valid, result_lo, result_hi, output ready);
endinterface

/* sv/ariu_round_dp.sv */
// Combinational AES round datapath: (Inv)ShiftRows, (Inv)SubBytes,
// (Inv)MixColumns and key XOR. Depends on ariu_pkg.
module ariu_round_dp (
  input  logic [2:0]            action,
  input  ariu_pkg::block_t      state_blk,
  input  ariu_pkg::block_t      key_blk,
  output ariu_pkg::block_t      result_blk
);
  import ariu_pkg::*;

  block_t sub_blk;
  block_t fmix_blk;
  block_t imix_src;
  block_t imix_blk;
  logic   inverse;

  assign inverse = (action == ACT_DEC) || (action == ACT_DEC_LAST);

  // Shift rows and substitute bytes
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) begin
          sub_blk[r + 4 * c] = INV_SUB_TBL[state_blk[r + 4 * ((c - r + 4) % 4)][7:4]]
                                          [state_blk[r + 4 * ((c - r + 4) % 4)][3:0]];
        end else begin
          sub_blk[r + 4 * c] = SBOX[state_blk[r + 4 * ((c + r) % 4)][7:4]]
                                   [state_blk[r + 4 * ((c + r) % 4)][3:0]];
        end
      end
    end
  end

  // Forward mix columns
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fmix_blk[r + 4 * c] = xtime(sub_blk[r + 4 * c])
          ^ xtime(sub_blk[(r + 1) % 4 + 4 * c]) ^ sub_blk[(r + 1) % 4 + 4 * c]
          ^ sub_blk[(r + 2) % 4 + 4 * c] ^ sub_blk[(r + 3) % 4 + 4 * c];
      end
    end
  end

  // Inverse mix columns: shared between decrypt round and key transform
  assign imix_src = (action == ACT_IMC) ? key_blk : sub_blk;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        imix_blk[r + 4 * c] = gf_mul(8'd14, imix_src[r + 4 * c])
          ^ gf_mul(8'd11, imix_src[(r + 1) % 4 + 4 * c])
          ^ gf_mul(8'd13, imix_src[(r + 2) % 4 + 4 * c])
          ^ gf_mul(8'd9, imix_src[(r + 3) % 4 + 4 * c]);
      end
    end
  end

  // Select the result by action
  always_comb begin
    unique case (action)
      ACT_ENC:      result_blk = fmix_blk ^ key_blk;
      ACT_ENC_LAST: result_blk = sub_blk ^ key_blk;
      ACT_DEC:      result_blk = imix_blk ^ key_blk;
      ACT_DEC_LAST: result_blk = sub_blk ^ key_blk;
      ACT_IMC:      result_blk = imix_blk;
      default:      result_blk = state_blk;
    endcase
  end
endmodule

/* sv/aes_round_instruction_unit.sv */
// AES round unit: accepts one transaction per cycle while in_ch.ready is high; each
// round passes the input register, a single-pass round datapath and the result
// register, for a throughput of one round per clock when nothing stalls. Stalls
// on the result side hold the result register, and the input register once
// it is full; the input side stays ready while the input register is empty
// or the result register is empty or being taken.
// Depends on ariu_pkg, ariu_if, ariu_round_dp and the macros header.
`include "aes_round_instruction_unit_macros.svh"

module aes_round_instruction_unit (
  input logic clk,
  input logic rst_n,
  ariu_in_if.sink    in_ch,
  ariu_out_if.source out_ch
);
  import ariu_pkg::*;

  logic        in_vld_r;
  logic [2:0]  act_r;
  block_t      st_r;
  block_t      key_r;
  logic        out_vld_r;
  block_t      res_r;
  block_t      res_nxt;
  logic        adv_out;
  logic        adv_in;
  logic        out_stall;

  // Advance the output stage when it is empty or drained
  assign adv_out = !out_vld_r || out_ch.ready;
  assign adv_in  = !in_vld_r || adv_out;
  assign in_ch.ready = adv_in;
  assign out_stall = out_vld_r && !out_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv_in) begin
      in_vld_r <= in_ch.valid;
    end
    if (adv_in && in_ch.valid) begin
      act_r <= in_ch.action;
      st_r  <= {in_ch.state_hi, in_ch.state_lo};
      key_r <= {in_ch.round_key_hi, in_ch.round_key_lo};
    end
  end

  ariu_round_dp u_dp (
    .action     (act_r),
    .state_blk  (st_r),
    .key_blk    (key_r),
    .result_blk (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv_out) begin
      out_vld_r <= in_vld_r;
    end
    if (adv_out && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.result_lo = res_r[7:0];
  assign out_ch.result_hi = res_r[15:8];

  `ARIU_ASSERT(a_stall_hold, out_stall |=> out_vld_r && $stable(res_r), "result moved in stall")
  `ARIU_ASSERT(a_move, in_vld_r && adv_out |=> out_vld_r, "transaction lost between stages")
  `ARIU_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_vld_r && !in_vld_r, "valid set after reset")
endmodule

/* tb/aes_round_checker.sv */
// Checker for the AES round instruction unit: watches both channels, predicts
// each round result and compares it with what the block returns.
// Depends on ariu_pkg and the ariu_in_if / ariu_out_if interfaces.
`timescale 1ns / 1ps

module aes_round_checker (
  input  logic   clk,
  input  logic   rst_n,
  ariu_in_if     in_ch,
  ariu_out_if    out_ch,
  output int     fail_count,
  output int     pending_rounds
);
  import ariu_pkg::*;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } round_result_t;

  round_result_t expected_rounds[$];

  function automatic byte_t mul2(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic byte_t field_mul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t t;
    acc = 8'h00;
    t = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= t;
      t = mul2(t);
    end
    return acc;
  endfunction

  // x^254, with zero mapping to zero
  function automatic byte_t field_inverse(input byte_t x);
    byte_t r;
    r = 8'h01;
    for (int k = 0; k < 254; k++) r = field_mul(r, x);
    return r;
  endfunction

  function automatic byte_t rot_left(input byte_t v, input int n);
    return byte_t'((v << n) | (v >> (8 - n)));
  endfunction

  function automatic byte_t forward_sub(input byte_t x);
    byte_t b;
    b = field_inverse(x);
    return b ^ rot_left(b, 1) ^ rot_left(b, 2) ^ rot_left(b, 3) ^ rot_left(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t backward_sub(input byte_t x);
    return field_inverse(rot_left(x, 1) ^ rot_left(x, 3) ^ rot_left(x, 6) ^ 8'h05);
  endfunction

  // Build substitution tables once so prediction stays fast.
  byte_t fwd_table[256];
  byte_t inv_table[256];
  initial begin
    for (int i = 0; i < 256; i++) begin
      fwd_table[i] = forward_sub(byte_t'(i));
      inv_table[i] = backward_sub(byte_t'(i));
    end
  end

  function automatic block_t column_mix(input block_t blk, input logic inverse);
    byte_t coef[4];
    block_t res;
    byte_t acc;
    if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= field_mul(coef[(k - r + 4) & 3], blk[k + 4 * c]);
        res[r + 4 * c] = acc;
      end
    end
    return res;
  endfunction

  function automatic round_result_t predict_round(input logic [2:0] act,
                                                  input logic [63:0] s_lo, s_hi,
                                                  input logic [63:0] k_lo, k_hi);
    block_t st;
    block_t key;
    block_t tmp;
    int src;
    logic inverse;
    st = {s_hi, s_lo};
    key = {k_hi, k_lo};
    inverse = (act == ACT_DEC) || (act == ACT_DEC_LAST);
    case (act) inside
      ACT_ENC, ACT_ENC_LAST, ACT_DEC, ACT_DEC_LAST: begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            src = inverse ? ((c - r + 4) & 3) : ((c + r) & 3);
            tmp[r + 4 * c] = inverse ? inv_table[st[r + 4 * src]]
                                     : fwd_table[st[r + 4 * src]];
          end
        end
        if (act == ACT_ENC || act == ACT_DEC) tmp = column_mix(tmp, inverse);
        tmp = tmp ^ key;
      end
      ACT_IMC: tmp = column_mix(key, 1'b1);
      default: tmp = st;
    endcase
    return '{lo: tmp[7:0], hi: tmp[15:8]};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got, exp_v);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    fail_count++;
  endtask

  // Predict on input transactions, compare on result transactions.
  always @(posedge clk) begin
    round_result_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_rounds.push_back(predict_round(in_ch.action, in_ch.state_lo, in_ch.state_hi,
                                                in_ch.round_key_lo, in_ch.round_key_hi));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rounds.size() == 0) begin
          report_mismatch("unexpected result", out_ch.result_lo, 64'h0);
        end else begin
          want = expected_rounds.pop_front();
          if (out_ch.result_lo !== want.lo)
            report_mismatch("result_lo", out_ch.result_lo, want.lo);
          if (out_ch.result_hi !== want.hi)
            report_mismatch("result_hi", out_ch.result_hi, want.hi);
        end
      end
    end
    pending_rounds = expected_rounds.size();
  end

endmodule

/* tb/aes_round_instruction_unit_test.sv */
// Top of the AES round instruction unit testbench: clock, reset, stimulus with
// bursty input and stalling output, and the verdict.
// Depends on ariu_pkg, the channel interfaces, the block and aes_round_checker.
`timescale 1ns / 1ps

module aes_round_instruction_unit_test;
  import ariu_pkg::*;

  localparam int RANDOM_ROUNDS = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count;
  int pending_rounds;

  ariu_in_if  in_ch (clk);
  ariu_out_if out_ch (clk);

  aes_round_instruction_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  aes_round_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending_rounds (pending_rounds)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side: alternate free-running stretches and random stalls.
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_phase <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 100) out_ch.ready <= 1'b1;
      else if (stall_phase < 250) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= ($urandom_range(0, 2) == 0);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Present one round and hold it until accepted; valid stays high afterwards.
  task automatic send_round(input logic [2:0] act, input logic [63:0] s_lo, s_hi,
                            input logic [63:0] k_lo, k_hi);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.state_lo <= s_lo;
    in_ch.state_hi <= s_hi;
    in_ch.round_key_lo <= k_lo;
    in_ch.round_key_hi <= k_hi;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_cycles(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [2:0] act;
    int burst;
    int sent;
    int drain;
    logic [63:0] ones;
    in_ch.valid = 1'b0;
    in_ch.action = 3'd0;
    in_ch.state_lo = '0;
    in_ch.state_hi = '0;
    in_ch.round_key_lo = '0;
    in_ch.round_key_hi = '0;
    ones = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every action at the operand extremes, unused codes, known vectors.
    for (int a = 0; a < 8; a++) begin
      send_round(3'(a), 64'h0, 64'h0, 64'h0, 64'h0);
      send_round(3'(a), ones, ones, ones, ones);
    end
    send_round(ACT_ENC, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
               64'h8899aabbccddeeff, 64'h0011223344556677);
    send_round(ACT_DEC, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, ones, 64'h0);
    send_round(ACT_IMC, 64'h0, 64'h0, 64'h0123456789abcdef, 64'hfedcba9876543210);

    // Random: bursts of rounds with random gaps; mostly valid actions.
    sent = 0;
    while (sent < RANDOM_ROUNDS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) begin
        act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_round(act, rand64(), rand64(), rand64(), rand64());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then allow the pipeline latency to settle.
    drain = 0;
    while (pending_rounds != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_rounds == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
